// ===== hw/rtl/i2cms_pkg.sv =====
package i2cms_pkg;

	localparam int TX_DEPTH_DEF = 256;
	localparam int Q_DEPTH = 2;
	localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;
	localparam logic [4:0] RETRY_SAT = 5'd31;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_EVENT = 2'd2;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_RX_ACK = 2'd1;
	localparam logic [1:0] CMD_STOP = 2'd2;
	localparam logic [1:0] CMD_NACK_STOP = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ARB = 2'd1;
	localparam logic [1:0] ST_NAK = 2'd2;
	localparam logic [1:0] ST_UNEXP = 2'd3;

	localparam int IN_BYTES = 6;
	localparam int OUT_BYTES = 6;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_START,
		OP_FAULT,
		OP_WR_NAK,
		OP_WR,
		OP_RD,
		OP_NOFLAG
	} op_t;

	// first field in the highest bits
	typedef struct packed {
		logic       nack_seen;
		logic       read_flag;
		logic       write_flag;
		logic       bus_error;
		logic       arb_lost;
		logic [7:0] rx_count;
		logic [7:0] tx_count;
		logic [6:0] slave_addr;
		logic [7:0] value;
		logic [7:0] buf_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       done_res;
		logic [7:0] rx_data;
		logic [7:0] rx_index;
		logic       rx_valid;
		logic       clear_arb;
		logic       force_idle;
		logic [1:0] bus_command;
		logic [7:0] data_out;
		logic       data_valid;
		logic [7:0] addr_byte;
		logic       addr_valid;
	} res_t;

	// f0/f1/f2: load {index, byte}, start {addr, tx, rx}, read {-, byte}
	typedef struct packed {
		op_t        op;
		logic [7:0] f0;
		logic [7:0] f1;
		logic [7:0] f2;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hw/rtl/i2cms_front.sv =====
module i2cms_front
	import i2cms_pkg::*;
(
	input  logic [1:0]             kind,
	input  logic [8*IN_BYTES-1:0]  data,
	output q_entry_t               entry
);

	in_item_t item;

	assign item = in_item_t'(data[$bits(in_item_t)-1:0]);

	always_comb begin
		entry.op = OP_NOP;
		entry.f0 = 8'd0;
		entry.f1 = item.value;
		entry.f2 = 8'd0;
		case (kind)
			KIND_LOAD: begin
				entry.op = OP_LOAD;
				entry.f0 = item.buf_index;
			end
			KIND_START: begin
				entry.op = OP_START;
				entry.f0 = {1'b0, item.slave_addr};
				entry.f1 = item.tx_count;
				entry.f2 = item.rx_count;
			end
			KIND_EVENT: begin
				// arbitration/bus error first, then write, then read
				if (item.arb_lost || item.bus_error)
					entry.op = OP_FAULT;
				else if (item.write_flag)
					entry.op = item.nack_seen ? OP_WR_NAK : OP_WR;
				else if (item.read_flag)
					entry.op = OP_RD;
				else
					entry.op = OP_NOFLAG;
			end
			default: entry.op = OP_NOP;
		endcase
	end

endmodule

// ===== hw/rtl/i2cms_queue.sv =====
module i2cms_queue
	import i2cms_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	input  logic     pop,
	output q_entry_t head,
	output q_stat_t  stat
);

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	q_entry_t        slot_q [Q_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign stat.full = (count_q == CW'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/i2cms_back.sv =====
module i2cms_back
	import i2cms_pkg::*;
#(
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [3:0] cfg_wdata,
	input  q_entry_t  head,
	input  logic      head_valid,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_ready,
	output res_t      res
);

	localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam logic [8:0] DEPTH_W = 9'(TX_DEPTH);

	logic [7:0]  mem_q [TX_DEPTH];
	logic [7:0]  mem_rd_q;

	logic [6:0]  slave_q;
	logic [7:0]  write_total_q;
	logic [7:0]  read_total_q;
	logic [7:0]  byte_pos_q;
	logic [4:0]  retry_count_q;
	logic [3:0]  retry_limit_q;

	res_t        res_s1;
	logic        mem_sel_s1;
	logic        out_valid_q;

	res_t        res_d;
	logic [7:0]  pos_d;
	logic [7:0]  pos_inc;
	logic        retry_ok;
	logic        retry_touch;
	logic [4:0]  retry_next;
	logic [7:0]  addr_issue;
	logic        mem_sel_d;
	logic        fire;

	assign fire = head_valid && (!out_valid_q || res_ready);
	assign pop = fire;

	assign retry_ok = (retry_count_q < {1'b0, retry_limit_q});
	assign retry_next = (retry_count_q == RETRY_SAT) ? retry_count_q : retry_count_q + 5'd1;
	assign addr_issue = {slave_q, (write_total_q == 8'd0)};
	assign pos_inc = byte_pos_q + 8'd1;

	always_comb begin
		res_d = '0;
		pos_d = byte_pos_q;
		retry_touch = 1'b0;
		mem_sel_d = 1'b0;
		case (head.op)
			OP_START: begin
				res_d.addr_valid = 1'b1;
				res_d.addr_byte = {head.f0[6:0], (head.f1 == 8'd0)};
				pos_d = 8'd0;
			end
			OP_FAULT: begin
				res_d.clear_arb = 1'b1;
				retry_touch = 1'b1;
				if (retry_ok) begin
					pos_d = 8'd0;
					res_d.addr_valid = 1'b1;
					res_d.addr_byte = addr_issue;
				end else begin
					res_d.done_res = 1'b1;
					res_d.status = ST_ARB;
				end
			end
			OP_WR_NAK: begin
				res_d.force_idle = 1'b1;
				retry_touch = 1'b1;
				if (retry_ok) begin
					pos_d = 8'd0;
					res_d.addr_valid = 1'b1;
					res_d.addr_byte = addr_issue;
				end else begin
					res_d.bus_command = CMD_STOP;
					res_d.done_res = 1'b1;
					res_d.status = ST_NAK;
				end
			end
			OP_WR: begin
				if (byte_pos_q < write_total_q) begin
					res_d.data_valid = 1'b1;
					mem_sel_d = ({1'b0, byte_pos_q} < DEPTH_W);
					pos_d = pos_inc;
				end else begin
					res_d.bus_command = CMD_STOP;
					res_d.force_idle = 1'b1;
					if (read_total_q != 8'd0) begin
						// repeated start for the read phase
						pos_d = 8'd0;
						res_d.addr_valid = 1'b1;
						res_d.addr_byte = {slave_q, 1'b1};
					end else begin
						res_d.done_res = 1'b1;
						res_d.status = ST_OK;
					end
				end
			end
			OP_RD: begin
				if (byte_pos_q < read_total_q) begin
					res_d.rx_valid = 1'b1;
					res_d.rx_index = byte_pos_q;
					res_d.rx_data = head.f1;
					res_d.bus_command = CMD_RX_ACK;
					pos_d = pos_inc;
				end
				if (pos_d >= read_total_q) begin
					res_d.bus_command = CMD_NACK_STOP;
					res_d.done_res = 1'b1;
					res_d.status = ST_OK;
				end
			end
			OP_NOFLAG: begin
				res_d.bus_command = CMD_STOP;
				res_d.done_res = 1'b1;
				res_d.status = ST_UNEXP;
			end
			default: res_d = '0;
		endcase
	end

	// transmit buffer, read registered alongside the result
	always_ff @(posedge clk) begin
		if (fire && head.op == OP_LOAD && ({1'b0, head.f0} < DEPTH_W))
			mem_q[head.f0[AW-1:0]] <= head.f1;
		if (fire)
			mem_rd_q <= mem_q[byte_pos_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1 <= res_d;
			mem_sel_s1 <= mem_sel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= '0;
			write_total_q <= '0;
			read_total_q <= '0;
			byte_pos_q <= '0;
			retry_count_q <= '0;
			retry_limit_q <= RETRY_LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				retry_limit_q <= cfg_wdata;
			if (fire) begin
				byte_pos_q <= pos_d;
				if (head.op == OP_START) begin
					slave_q <= head.f0[6:0];
					write_total_q <= head.f1;
					read_total_q <= head.f2;
					retry_count_q <= '0;
				end else if (retry_touch) begin
					retry_count_q <= retry_next;
				end
			end
			if (fire)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		res = res_s1;
		res.data_out = mem_sel_s1 ? mem_rd_q : 8'd0;
	end

	assign res_valid = out_valid_q;

endmodule

// ===== hw/rtl/i2c_master_txn_sequencer_top.sv =====
// channel  | handshake          | payload
// s        | s_tvalid/s_tready  | s_tuser kind, s_tdata event/start/load fields
// m        | m_tvalid/m_tready  | m_tdata result fields
// cfg      | cfg_we             | cfg_wdata retry_limit
//
// one transaction per cycle sustained when nothing stalls; a taken transaction
// passes through a queue slot, then the result register, before its result leaves
// the transmit buffer read is registered together with the result
// reset clears the queue, the sequencing state and sets retry_limit to 3
// a stall on m backs up the two-entry queue, then drops s_tready
module i2c_master_txn_sequencer_top
	import i2cms_pkg::*;
#(
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// buf_index, value, slave_addr, tx_count, rx_count, arb_lost, bus_error,
	// write_flag, read_flag, nack_seen, zero pad
	input  logic [8*IN_BYTES-1:0]  s_tdata,
	// kind
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// addr_valid, addr_byte, data_valid, data_out, bus_command, force_idle,
	// clear_arb, rx_valid, rx_index, rx_data, done_res, status, zero pad
	output logic [8*OUT_BYTES-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [3:0]             cfg_wdata
);

	q_entry_t entry;
	q_entry_t head;
	q_stat_t  q_stat;
	logic     pop;
	logic     push;
	res_t     res;

	assign s_tready = !q_stat.full;
	assign push = s_tvalid && s_tready;

	i2cms_front u_front (
		.kind  (s_tuser),
		.data  (s_tdata),
		.entry (entry)
	);

	i2cms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	i2cms_back #(
		.TX_DEPTH (TX_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.head       (head),
		.head_valid (!q_stat.empty),
		.pop        (pop),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {{(8*OUT_BYTES-$bits(res_t)){1'b0}}, res};

`ifndef SYNTH
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("back end took from an empty queue");

	a_addr_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res.addr_valid && res.done_res))
		else $error("address issued on a completed transaction");

	a_rx_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.rx_valid) |->
			(res.bus_command == CMD_RX_ACK || res.bus_command == CMD_NACK_STOP))
		else $error("received byte without receive command");

	a_data_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.data_valid) |->
			(res.bus_command == CMD_NONE && !res.done_res && !res.addr_valid))
		else $error("data byte mixed with other bus action");
`endif

endmodule

// ===== tb/sv/i2c_master_txn_sequencer_top_tb.sv =====
`timescale 1ns / 1ps

module i2c_master_txn_sequencer_top_tb;
	import i2cms_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int RES_BITS = $bits(res_t);
	localparam int ITEM_BITS = $bits(in_item_t);

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [8*IN_BYTES-1:0]  s_tdata = '0;
	logic [1:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [8*OUT_BYTES-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [3:0]             cfg_wdata = '0;

	i2c_master_txn_sequencer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// sequencer state as the testbench tracks it
	bit [7:0] tx_mirror [256];
	bit [7:0] addr_sh;
	bit [7:0] wr_total;
	bit [7:0] rd_total;
	bit [7:0] byte_pos;
	bit [4:0] retries;
	bit [3:0] retry_cap = RETRY_LIMIT_RST;
	bit       reading_phase;

	res_t pending_results[$];
	res_t last_actions;
	int   mismatches = 0;
	int   bus_items = 0;
	int   send_idle_pct = 0;
	int   rx_stall_pct = 0;
	int   hold_left = 0;

	function automatic bit take_retry();
		bit ok;
		ok = {3'b000, retries} < {4'b0000, retry_cap};
		if (retries != RETRY_SAT)
			retries++;
		return ok;
	endfunction

	function automatic res_t next_bus_actions(input logic [1:0] kind, input in_item_t it);
		res_t r;
		r = '0;
		case (kind)
			KIND_LOAD: begin
				tx_mirror[it.buf_index] = it.value;
			end
			KIND_START: begin
				addr_sh = {it.slave_addr, 1'b0};
				wr_total = it.tx_count;
				rd_total = it.rx_count;
				byte_pos = '0;
				retries = '0;
				reading_phase = (wr_total == 8'd0);
				r.addr_valid = 1'b1;
				r.addr_byte = addr_sh | {7'd0, reading_phase};
			end
			KIND_EVENT: begin
				if (it.arb_lost || it.bus_error) begin
					r.clear_arb = 1'b1;
					if (take_retry()) begin
						byte_pos = '0;
						reading_phase = (wr_total == 8'd0);
						r.addr_valid = 1'b1;
						r.addr_byte = addr_sh | {7'd0, reading_phase};
					end else begin
						r.done_res = 1'b1;
						r.status = ST_ARB;
					end
				end else if (it.write_flag) begin
					if (it.nack_seen) begin
						r.force_idle = 1'b1;
						if (take_retry()) begin
							byte_pos = '0;
							reading_phase = (wr_total == 8'd0);
							r.addr_valid = 1'b1;
							r.addr_byte = addr_sh | {7'd0, reading_phase};
						end else begin
							r.bus_command = CMD_STOP;
							r.done_res = 1'b1;
							r.status = ST_NAK;
						end
					end else if (byte_pos < wr_total) begin
						r.data_valid = 1'b1;
						r.data_out = tx_mirror[byte_pos];
						byte_pos++;
					end else begin
						r.bus_command = CMD_STOP;
						r.force_idle = 1'b1;
						if (rd_total != 8'd0) begin
							// repeated start for the read part
							byte_pos = '0;
							reading_phase = 1'b1;
							r.addr_valid = 1'b1;
							r.addr_byte = addr_sh | 8'd1;
						end else begin
							r.done_res = 1'b1;
							r.status = ST_OK;
						end
					end
				end else if (it.read_flag) begin
					if (byte_pos < rd_total) begin
						r.rx_valid = 1'b1;
						r.rx_index = byte_pos;
						r.rx_data = it.value;
						r.bus_command = CMD_RX_ACK;
						byte_pos++;
					end
					if (byte_pos >= rd_total) begin
						r.bus_command = CMD_NACK_STOP;
						r.done_res = 1'b1;
						r.status = ST_OK;
					end
				end else begin
					r.bus_command = CMD_STOP;
					r.done_res = 1'b1;
					r.status = ST_UNEXP;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// result checker
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[RES_BITS-1:0]);
			if (pending_results.size() == 0) begin
				flag_mismatch("result with nothing expected");
			end else begin
				want = pending_results.pop_front();
				cmp_field("addr_valid", got.addr_valid, want.addr_valid);
				cmp_field("addr_byte", got.addr_byte, want.addr_byte);
				cmp_field("data_valid", got.data_valid, want.data_valid);
				cmp_field("data_out", got.data_out, want.data_out);
				cmp_field("bus_command", got.bus_command, want.bus_command);
				cmp_field("force_idle", got.force_idle, want.force_idle);
				cmp_field("clear_arb", got.clear_arb, want.clear_arb);
				cmp_field("rx_valid", got.rx_valid, want.rx_valid);
				cmp_field("rx_index", got.rx_index, want.rx_index);
				cmp_field("rx_data", got.rx_data, want.rx_data);
				cmp_field("done_res", got.done_res, want.done_res);
				cmp_field("status", got.status, want.status);
			end
		end
	end

	// receiver: long hold-off when requested, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	task automatic send_item(input logic [1:0] kind, input in_item_t it);
		bit rdy;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {{(8*IN_BYTES-ITEM_BITS){1'b0}}, it};
		// ready is settled by the falling edge
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		last_actions = next_bus_actions(kind, it);
		pending_results.push_back(last_actions);
		if (kind == KIND_START || kind == KIND_EVENT)
			bus_items++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_retry_limit(input logic [3:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		retry_cap = v;
	endtask

	function automatic in_item_t rand_fields();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[ITEM_BITS-1:0];
	endfunction

	function automatic in_item_t mk_load(input logic [7:0] idx, input logic [7:0] val);
		in_item_t it;
		it = rand_fields();
		it.buf_index = idx;
		it.value = val;
		return it;
	endfunction

	function automatic in_item_t mk_start(input logic [6:0] addr, input logic [7:0] txn,
			input logic [7:0] rxn);
		in_item_t it;
		it = rand_fields();
		it.slave_addr = addr;
		it.tx_count = txn;
		it.rx_count = rxn;
		return it;
	endfunction

	function automatic in_item_t mk_event(input bit arb, input bit berr, input bit wf,
			input bit rf, input bit nak);
		in_item_t it;
		it = rand_fields();
		it.arb_lost = arb;
		it.bus_error = berr;
		it.write_flag = wf;
		it.read_flag = rf;
		it.nack_seen = nak;
		return it;
	endfunction

	task automatic run_txn();
		logic [7:0] txn;
		logic [7:0] rxn;
		logic [1:0] fault;
		int steps;
		int r;
		in_item_t ev;
		// mostly short transactions, now and then a full-range one
		txn = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 6));
		rxn = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 6));
		send_item(KIND_START, mk_start(7'($urandom()), txn, rxn));
		steps = 0;
		while (!last_actions.done_res && steps < 400) begin
			r = $urandom_range(0, 99);
			fault = 2'($urandom_range(1, 3));
			if (r < 3)
				ev = mk_event(fault[0], fault[1], 1'($urandom()), 1'($urandom()), 1'($urandom()));
			else if (r < 6 && !reading_phase)
				ev = mk_event(1'b0, 1'b0, 1'b1, 1'($urandom()), 1'b1);
			else if (r < 7)
				ev = mk_event(1'b0, 1'b0, 1'b0, 1'b0, 1'($urandom()));
			else if (reading_phase)
				ev = mk_event(1'b0, 1'b0, 1'b0, 1'b1, 1'($urandom()));
			else
				ev = mk_event(1'b0, 1'b0, 1'b1, 1'($urandom()), 1'b0);
			send_item(KIND_EVENT, ev);
			steps++;
		end
		// stray event after completion
		if ($urandom_range(0, 7) == 0)
			send_item(KIND_EVENT, rand_fields());
	endtask

	task automatic run_random(input int n);
		int stop_at;
		stop_at = bus_items + n;
		while (bus_items < stop_at) begin
			if ($urandom_range(0, 99) < 5) begin
				case ($urandom_range(0, 2))
					0: send_item(KIND_SPARE, rand_fields());
					1: send_item(KIND_LOAD, rand_fields());
					default: send_item(KIND_EVENT, rand_fields());
				endcase
			end else begin
				run_txn();
			end
		end
	endtask

	// every buffer entry gets written before any transmit read
	task automatic test_buffer_fill();
		for (int i = 0; i < 256; i++)
			send_item(KIND_LOAD, mk_load(8'(i), 8'($urandom())));
	endtask

	task automatic test_directed();
		send_item(KIND_LOAD, mk_load(8'd255, 8'hFF));
		send_item(KIND_LOAD, mk_load(8'd0, 8'h00));
		send_item(KIND_SPARE, rand_fields());
		// write two, read two, then an event after completion
		send_item(KIND_START, mk_start(7'd127, 8'd2, 8'd2));
		repeat (3) send_item(KIND_EVENT, mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
		repeat (3) send_item(KIND_EVENT, mk_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
		// nothing to write or read, retries used up by mixed faults
		send_item(KIND_START, mk_start(7'd0, 8'd0, 8'd0));
		send_item(KIND_EVENT, mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
		send_item(KIND_EVENT, mk_event(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		send_item(KIND_EVENT, mk_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
		send_item(KIND_EVENT, mk_event(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		// slave nak until the block gives up
		send_item(KIND_START, mk_start(7'h55, 8'd1, 8'd0));
		repeat (4) send_item(KIND_EVENT, mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
		// unexpected interrupt, then an empty transfer completing on a write event
		send_item(KIND_EVENT, mk_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_item(KIND_START, mk_start(7'h2A, 8'd0, 8'd0));
		send_item(KIND_EVENT, mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
		send_item(KIND_EVENT, mk_event(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
	endtask

	task automatic test_retry_extremes();
		set_retry_limit(4'd0);
		send_item(KIND_START, mk_start(7'h11, 8'd1, 8'd1));
		send_item(KIND_EVENT, mk_event(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		send_item(KIND_START, mk_start(7'h22, 8'd1, 8'd1));
		send_item(KIND_EVENT, mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
		set_retry_limit(4'd15);
		// enough faults to run the retry counter into saturation
		send_item(KIND_START, mk_start(7'h3C, 8'd3, 8'd2));
		for (int i = 0; i < 40; i++) begin
			case (i % 3)
				0: send_item(KIND_EVENT, mk_event(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
				1: send_item(KIND_EVENT, mk_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
				default: send_item(KIND_EVENT, mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
			endcase
		end
		send_item(KIND_EVENT, mk_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
	endtask

	task automatic test_random_phases();
		set_retry_limit(4'd15);
		send_idle_pct = 0;
		rx_stall_pct = 0;
		run_random(280);
		set_retry_limit(4'd0);
		send_idle_pct = 73;
		rx_stall_pct = 0;
		run_random(280);
		set_retry_limit(4'($urandom_range(1, 14)));
		send_idle_pct = 0;
		rx_stall_pct = 73;
		run_random(280);
		set_retry_limit(4'($urandom_range(0, 15)));
		send_idle_pct = 31;
		rx_stall_pct = 31;
		run_random(280);
	endtask

	task automatic test_backpressure();
		set_retry_limit(4'd3);
		send_idle_pct = 0;
		rx_stall_pct = 0;
		// receiver holds off while the sender keeps offering
		hold_left = 150;
		run_random(40);
		// sender pauses until the block has caught up
		drain();
		run_random(30);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_buffer_fill();
		test_directed();
		test_retry_extremes();
		test_random_phases();
		test_backpressure();
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("FAIL");
		$finish;
	end

endmodule
